/* sv/lss_pkg.sv */
`timescale 1ns / 1ps

package lss_pkg;

   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [7:0] CMD_SWITCH_GLOBAL  = 8'h04;
   localparam logic [7:0] CMD_CONFIG_NODE_ID = 8'h11;
   localparam logic [7:0] CMD_STORE_CONFIG   = 8'h17;
   localparam logic [7:0] CMD_SEL_VENDOR     = 8'h40;
   localparam logic [7:0] CMD_SEL_PRODUCT    = 8'h41;
   localparam logic [7:0] CMD_SEL_REVISION   = 8'h42;
   localparam logic [7:0] CMD_SEL_SERIAL     = 8'h43;
   localparam logic [7:0] CMD_QUERY_VENDOR   = 8'h5A;
   localparam logic [7:0] CMD_QUERY_PRODUCT  = 8'h5B;
   localparam logic [7:0] CMD_QUERY_REVISION = 8'h5C;
   localparam logic [7:0] CMD_QUERY_SERIAL   = 8'h5D;
   localparam logic [7:0] CMD_QUERY_NODE_ID  = 8'h5E;

   localparam logic [CSR_INDEX_W-1:0] REG_VENDOR_ID       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRODUCT_CODE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REVISION_NUMBER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SERIAL_NUMBER   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_NODE_ID = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STORE_RESULT    = 3'd5;

   localparam logic [6:0]  NODE_ID_UNSET      = 7'h00;
   localparam logic [15:0] STORE_RESULT_RESET = 16'h0001;
   localparam logic [7:0]  STORE_ERR_SPECIFIC = 8'hFF;
   localparam logic [31:0] STORE_NO_NODE_ID   = 32'h0000_0101;

   localparam logic [1:0] STAGE_VENDOR   = 2'd0;
   localparam logic [1:0] STAGE_PRODUCT  = 2'd1;
   localparam logic [1:0] STAGE_REVISION = 2'd2;
   localparam logic [1:0] STAGE_SERIAL   = 2'd3;

   typedef struct packed {
      logic [31:0] vendor_id;
      logic [31:0] product_code;
      logic [31:0] revision_number;
      logic [31:0] serial_number;
      logic [15:0] store_result;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic [6:0] node_id;
   } node_load_type;

   typedef struct packed {
      logic        emit;
      logic [31:0] data;
   } result_type;

   typedef struct packed {
      logic       config_mode;
      logic [1:0] select_stage;
      logic [6:0] node_address;
   } status_type;

endpackage

/* sv/lss_if.sv */
`timescale 1ns / 1ps

interface lss_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command;
   logic [31:0] argument;

   modport source (output valid, output command, output argument, input ready);
   modport sink (input valid, input command, input argument, output ready);
endinterface

interface lss_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  reply_command;
   logic [31:0] reply_data;

   modport source (output valid, output reply_command, output reply_data, input ready);
   modport sink (input valid, input reply_command, input reply_data, output ready);
endinterface

interface lss_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/lss_csr_regs.sv */
`timescale 1ns / 1ps

module lss_csr_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [lss_pkg::CSR_INDEX_W-1:0]      wr_index,
   input  logic [31:0]                          wr_data,
   output lss_pkg::cfg_type                     cfg,
   output lss_pkg::node_load_type               node_load
);
   import lss_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vendor_id       <= '0;
         cfg_ff.product_code    <= '0;
         cfg_ff.revision_number <= '0;
         cfg_ff.serial_number   <= '0;
         cfg_ff.store_result    <= STORE_RESULT_RESET;
      end else if (wr_en) begin
         case (wr_index)
            REG_VENDOR_ID:       cfg_ff.vendor_id       <= wr_data;
            REG_PRODUCT_CODE:    cfg_ff.product_code    <= wr_data;
            REG_REVISION_NUMBER: cfg_ff.revision_number <= wr_data;
            REG_SERIAL_NUMBER:   cfg_ff.serial_number   <= wr_data;
            REG_STORE_RESULT:    cfg_ff.store_result    <= wr_data[15:0];
            default: ;
         endcase
      end
   end

   // initial node id is not kept: it goes straight into the node address
   assign node_load.load    = wr_en && (wr_index == REG_INITIAL_NODE_ID);
   assign node_load.node_id = wr_data[6:0];
   assign cfg               = cfg_ff;

endmodule

/* sv/lss_cmd_decode.sv */
`timescale 1ns / 1ps

module lss_cmd_decode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [7:0]                command,
   input  logic [31:0]               argument,
   input  lss_pkg::cfg_type          cfg,
   input  lss_pkg::node_load_type    node_load,
   output lss_pkg::result_type       result,
   output lss_pkg::status_type       status
);
   import lss_pkg::*;

   logic       mode_ff, mode_in;
   logic [1:0] stage_ff, stage_in;
   logic [6:0] node_ff, node_in;
   logic [7:0] b1;

   assign b1 = argument[7:0];

   always_comb begin
      mode_in     = mode_ff;
      stage_in    = stage_ff;
      node_in     = node_ff;
      result.emit = 1'b0;
      result.data = '0;
      case (command)
         CMD_SWITCH_GLOBAL: begin
            if (b1 == 8'd1) begin
               mode_in = 1'b1;
            end else if (b1 == 8'd0) begin
               mode_in = 1'b0;
            end
            stage_in = STAGE_VENDOR;
         end
         CMD_CONFIG_NODE_ID: begin
            if (mode_ff) begin
               result.emit = 1'b1;
               if (b1 == 8'd0 || b1[7]) begin
                  result.data = 32'd1;
               end else begin
                  node_in = b1[6:0];
               end
            end
         end
         CMD_STORE_CONFIG: begin
            if (mode_ff) begin
               result.emit = 1'b1;
               if (node_ff == NODE_ID_UNSET) begin
                  result.data = STORE_NO_NODE_ID;
               end else if (cfg.store_result[7:0] == STORE_ERR_SPECIFIC) begin
                  result.data = {16'd0, cfg.store_result};
               end else begin
                  result.data = {24'd0, cfg.store_result[7:0]};
               end
            end
         end
         CMD_SEL_VENDOR: begin
            if (argument == cfg.vendor_id) begin
               stage_in = STAGE_PRODUCT;
            end
         end
         CMD_SEL_PRODUCT: begin
            if (stage_ff != STAGE_VENDOR && argument == cfg.product_code) begin
               stage_in = STAGE_REVISION;
            end
         end
         CMD_SEL_REVISION: begin
            if ((stage_ff == STAGE_REVISION || stage_ff == STAGE_SERIAL)
                && argument == cfg.revision_number) begin
               stage_in = STAGE_SERIAL;
            end
         end
         CMD_SEL_SERIAL: begin
            if (stage_ff == STAGE_SERIAL && argument == cfg.serial_number) begin
               mode_in     = !mode_ff;
               stage_in    = STAGE_VENDOR;
               result.emit = 1'b1;
               // answer is one when leaving configuration mode
               result.data = {31'd0, mode_ff};
            end
         end
         CMD_QUERY_VENDOR: begin
            result.emit = mode_ff;
            result.data = cfg.vendor_id;
         end
         CMD_QUERY_PRODUCT: begin
            result.emit = mode_ff;
            result.data = cfg.product_code;
         end
         CMD_QUERY_REVISION: begin
            result.emit = mode_ff;
            result.data = cfg.revision_number;
         end
         CMD_QUERY_SERIAL: begin
            result.emit = mode_ff;
            result.data = cfg.serial_number;
         end
         CMD_QUERY_NODE_ID: begin
            result.emit = mode_ff;
            result.data = {25'd0, node_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         stage_ff <= STAGE_VENDOR;
         node_ff  <= NODE_ID_UNSET;
      end else if (node_load.load) begin
         node_ff <= node_load.node_id;
      end else if (fire) begin
         mode_ff  <= mode_in;
         stage_ff <= stage_in;
         node_ff  <= node_in;
      end
   end

   assign status.config_mode  = mode_ff;
   assign status.select_stage = stage_ff;
   assign status.node_address = node_ff;

endmodule

/* sv/lss_slave_command_handler.sv */
`timescale 1ns / 1ps
// a response is registered in the response register when its request leaves the request register
// throughput: one request per cycle while the response side takes its results
// the request register and the response register decouple the two channels
// reset: control state cleared, identity registers 0, store result code 1,
// node address 0, configuration mode off and selection restarted

module lss_slave_command_handler (
   input logic      clock,
   input logic      reset,
   lss_req_if.sink  req_chan,
   lss_rsp_if.source rsp_chan,
   lss_csr_if.sink  csr_chan
);
   import lss_pkg::*;

   logic        req_valid_ff;
   logic [7:0]  req_command_ff;
   logic [31:0] req_argument_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_command_ff;
   logic [31:0] rsp_data_ff;
   logic        advance;
   logic        req_fire;

   cfg_type       cfg;
   node_load_type node_load;
   result_type    result;
   status_type    status;

   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   lss_csr_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (csr_chan.valid),
      .wr_index  (csr_chan.index),
      .wr_data   (csr_chan.data),
      .cfg       (cfg),
      .node_load (node_load)
   );

   lss_cmd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .command   (req_command_ff),
      .argument  (req_argument_ff),
      .cfg       (cfg),
      .node_load (node_load),
      .result    (result),
      .status    (status)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
      if (req_fire) begin
         req_command_ff  <= req_chan.command;
         req_argument_ff <= req_chan.argument;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result.emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && result.emit) begin
         rsp_command_ff <= req_command_ff;
         rsp_data_ff    <= result.data;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.reply_command = rsp_command_ff;
   assign rsp_chan.reply_data    = rsp_data_ff;

`ifndef SYNTHESIS
   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid after reset");

   a_no_switch_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_command_ff != CMD_SWITCH_GLOBAL))
      else $error("reply to a global switch command");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |-> (rsp_valid_ff && !rsp_chan.ready))
      else $error("request held without a blocked response");

   a_serial_stage_order: assert property (@(posedge clock) disable iff (reset)
      (status.select_stage == STAGE_SERIAL && $past(status.select_stage) != STAGE_SERIAL
       && !$past(reset))
      |-> ($past(status.select_stage) == STAGE_REVISION))
      else $error("selection reached serial stage out of order");
`endif

endmodule
